FILE: hw/rtl/lrc_pkg.sv
// Types, widths and helper functions shared by the line/rectangle clipper.
`default_nettype none
package lrc_pkg;

    localparam int COORD_W  = 16;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int VAL_W    = PROD_W + 2;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES = PROD_W / DIV_STEPS_PER_STAGE;

    // lane order: left, right, top, bottom crossing
    localparam int LANE_L = 0;
    localparam int LANE_R = 1;
    localparam int LANE_T = 2;
    localparam int LANE_B = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COORD_W-1:0]        mag_t;
    typedef logic [COORD_W:0]          diff_t;

    typedef struct packed {
        coord_t rect_left;
        coord_t rect_top;
        coord_t rect_right;
        coord_t rect_bottom;
        coord_t seg_start_x;
        coord_t seg_start_y;
        coord_t seg_end_x;
        coord_t seg_end_y;
    } in_t;

    typedef struct packed {
        coord_t clip_start_x;
        coord_t clip_start_y;
        coord_t clip_end_x;
        coord_t clip_end_y;
        logic   has_overlap;
    } out_t;

    typedef struct packed {
        mag_t              rem;
        logic [PROD_W-1:0] num;
    } lane_t;

    typedef struct packed {
        in_t             ctx;
        mag_t            dxm;
        mag_t            dym;
        logic [3:0][COORD_W-1:0] mag;
        logic [3:0]      neg;
    } prep_t;

    typedef struct packed {
        in_t             ctx;
        mag_t            dxm;
        mag_t            dym;
        logic [3:0]      neg;
        lane_t [3:0]     lane;
    } div_t;

    typedef struct packed {
        in_t                     ctx;
        logic [3:0][COORD_W-1:0] cval;
        logic [3:0]              acc;
        logic                    in_a;
        logic                    in_b;
        logic                    degen;
    } fin_t;

    function automatic diff_t sub_ext(input coord_t a, input coord_t b);
        diff_t r;
        r = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return r;
    endfunction

    function automatic mag_t abs_mag(input diff_t d);
        diff_t r;
        r = d[COORD_W] ? (~d + diff_t'(1)) : d;
        return r[COORD_W-1:0];
    endfunction

    // one restoring division step: shift in the next dividend bit
    function automatic lane_t div_step(input lane_t x, input mag_t d);
        logic [COORD_W:0] sh;
        lane_t            y;
        sh    = {x.rem, x.num[PROD_W-1]};
        y.num = {x.num[PROD_W-2:0], 1'b0};
        if (sh >= {1'b0, d}) begin
            sh       = sh - {1'b0, d};
            y.num[0] = 1'b1;
        end
        y.rem = sh[COORD_W-1:0];
        return y;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/lrc_front.sv
// Front stages: edge differences and magnitudes, then the four products.
`default_nettype none
module lrc_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  wire lrc_pkg::in_t  in_data,
    output logic               in_ready,
    output logic               out_valid,
    output lrc_pkg::div_t      out_data,
    input  wire logic          out_ready
);

    logic             p1_v_reg, p2_v_reg;
    lrc_pkg::prep_t   p1_reg, p1_next;
    lrc_pkg::div_t    p2_reg, p2_next;
    logic             rdy1, rdy2;

    assign rdy2     = !p2_v_reg || out_ready;
    assign rdy1     = !p1_v_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        lrc_pkg::diff_t dx, dy, tl, tr, tt, tb;
        dx = lrc_pkg::sub_ext(in_data.seg_end_x, in_data.seg_start_x);
        dy = lrc_pkg::sub_ext(in_data.seg_end_y, in_data.seg_start_y);
        tl = lrc_pkg::sub_ext(in_data.rect_left, in_data.seg_start_x);
        tr = lrc_pkg::sub_ext(in_data.rect_right, in_data.seg_start_x);
        tt = lrc_pkg::sub_ext(in_data.rect_top, in_data.seg_start_y);
        tb = lrc_pkg::sub_ext(in_data.rect_bottom, in_data.seg_start_y);
        p1_next.ctx = in_data;
        p1_next.dxm = lrc_pkg::abs_mag(dx);
        p1_next.dym = lrc_pkg::abs_mag(dy);
        p1_next.mag[lrc_pkg::LANE_L] = lrc_pkg::abs_mag(tl);
        p1_next.mag[lrc_pkg::LANE_R] = lrc_pkg::abs_mag(tr);
        p1_next.mag[lrc_pkg::LANE_T] = lrc_pkg::abs_mag(tt);
        p1_next.mag[lrc_pkg::LANE_B] = lrc_pkg::abs_mag(tb);
        p1_next.neg[lrc_pkg::LANE_L] = tl[lrc_pkg::COORD_W] ^ dy[lrc_pkg::COORD_W]
                                     ^ dx[lrc_pkg::COORD_W];
        p1_next.neg[lrc_pkg::LANE_R] = tr[lrc_pkg::COORD_W] ^ dy[lrc_pkg::COORD_W]
                                     ^ dx[lrc_pkg::COORD_W];
        p1_next.neg[lrc_pkg::LANE_T] = tt[lrc_pkg::COORD_W] ^ dx[lrc_pkg::COORD_W]
                                     ^ dy[lrc_pkg::COORD_W];
        p1_next.neg[lrc_pkg::LANE_B] = tb[lrc_pkg::COORD_W] ^ dx[lrc_pkg::COORD_W]
                                     ^ dy[lrc_pkg::COORD_W];
    end

    always_comb begin
        p2_next.ctx = p1_reg.ctx;
        p2_next.dxm = p1_reg.dxm;
        p2_next.dym = p1_reg.dym;
        p2_next.neg = p1_reg.neg;
        // x-edge crossings scale by |dy|, y-edge crossings by |dx|
        p2_next.lane[lrc_pkg::LANE_L].num = p1_reg.mag[lrc_pkg::LANE_L] * p1_reg.dym;
        p2_next.lane[lrc_pkg::LANE_R].num = p1_reg.mag[lrc_pkg::LANE_R] * p1_reg.dym;
        p2_next.lane[lrc_pkg::LANE_T].num = p1_reg.mag[lrc_pkg::LANE_T] * p1_reg.dxm;
        p2_next.lane[lrc_pkg::LANE_B].num = p1_reg.mag[lrc_pkg::LANE_B] * p1_reg.dxm;
        for (int j = 0; j < 4; j++) begin
            p2_next.lane[j].rem = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
        end else begin
            if (rdy1) p1_v_reg <= in_valid;
            if (rdy2) p2_v_reg <= p1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) p1_reg <= p1_next;
        if (rdy2) p2_reg <= p2_next;
    end

    assign out_valid = p2_v_reg;
    assign out_data  = p2_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/lrc_div.sv
// Pipelined restoring divider, four lanes, two quotient bits per stage.
`default_nettype none
module lrc_div (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  wire lrc_pkg::div_t in_data,
    output logic               in_ready,
    output logic               out_valid,
    output lrc_pkg::div_t      out_data,
    input  wire logic          out_ready
);

    localparam int N = lrc_pkg::DIV_STAGES;

    logic          v_arr [0:N];
    lrc_pkg::div_t d_arr [0:N];
    logic          rdy   [0:N];

    assign v_arr[0] = in_valid;
    assign d_arr[0] = in_data;
    assign rdy[N]   = out_ready;
    assign in_ready = rdy[0];

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic          v_reg;
        lrc_pkg::div_t d_reg, d_next;

        assign rdy[i]       = !v_reg || rdy[i+1];
        assign v_arr[i+1]   = v_reg;
        assign d_arr[i+1]   = d_reg;

        always_comb begin
            d_next = d_arr[i];
            for (int j = 0; j < 4; j++) begin
                for (int s = 0; s < lrc_pkg::DIV_STEPS_PER_STAGE; s++) begin
                    d_next.lane[j] = lrc_pkg::div_step(d_next.lane[j],
                                                       (j < 2) ? d_arr[i].dxm : d_arr[i].dym);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (rdy[i]) begin
                v_reg <= v_arr[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[i]) d_reg <= d_next;
        end
    end

    assign out_valid = v_arr[N];
    assign out_data  = d_arr[N];

endmodule
`default_nettype wire

FILE: hw/rtl/lrc_back.sv
// Back stages: crossing values and tests, then point selection and output register.
`default_nettype none
module lrc_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  wire lrc_pkg::div_t in_data,
    output logic               in_ready,
    output logic               out_valid,
    output lrc_pkg::out_t      out_data,
    input  wire logic          out_ready
);

    localparam int W  = lrc_pkg::COORD_W;
    localparam int VW = lrc_pkg::VAL_W;

    logic           f1_v_reg, o_v_reg;
    lrc_pkg::fin_t  f1_reg, f1_next;
    lrc_pkg::out_t  o_reg, o_next;
    logic           rdy1, rdy2;

    assign rdy2     = !o_v_reg || out_ready;
    assign rdy1     = !f1_v_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        logic signed [VW-1:0] val [4];
        logic signed [VW-1:0] base, q;
        lrc_pkg::coord_t      l, t, r, b, ax, ay, bx, by, e;
        logic                 span, inr, nz;
        l  = in_data.ctx.rect_left;
        t  = in_data.ctx.rect_top;
        r  = in_data.ctx.rect_right;
        b  = in_data.ctx.rect_bottom;
        ax = in_data.ctx.seg_start_x;
        ay = in_data.ctx.seg_start_y;
        bx = in_data.ctx.seg_end_x;
        by = in_data.ctx.seg_end_y;
        f1_next.ctx = in_data.ctx;
        for (int j = 0; j < 4; j++) begin
            base = (j < 2) ? VW'(ay) : VW'(ax);
            q    = {2'b00, in_data.lane[j].num};
            val[j] = in_data.neg[j] ? (base - q) : (base + q);
            f1_next.cval[j] = val[j][W-1:0];
            case (j)
                lrc_pkg::LANE_L: e = l;
                lrc_pkg::LANE_R: e = r;
                lrc_pkg::LANE_T: e = t;
                default:         e = b;
            endcase
            if (j < 2) begin
                nz   = (ax != bx);
                span = (ax <= e && e <= bx) || (bx <= e && e <= ax);
                inr  = (VW'(t) <= val[j]) && (val[j] <= VW'(b));
            end else begin
                nz   = (ay != by);
                span = (ay <= e && e <= by) || (by <= e && e <= ay);
                inr  = (VW'(l) <= val[j]) && (val[j] <= VW'(r));
            end
            f1_next.acc[j] = nz && span && inr;
        end
        f1_next.in_a  = (l <= ax) && (r > ax) && (t <= ay) && (b > ay);
        f1_next.in_b  = (l <= bx) && (r > bx) && (t <= by) && (b > by);
        f1_next.degen = (ax == bx && ay == by) || (l == r) || (t == b);
    end

    always_comb begin
        logic [1:0]      n;
        lrc_pkg::coord_t px0, py0, px1, py1, cx, cy;
        n = 2'd0;
        px0 = '0; py0 = '0; px1 = '0; py1 = '0;
        if (f1_reg.in_a) begin
            px0 = f1_reg.ctx.seg_start_x;
            py0 = f1_reg.ctx.seg_start_y;
            n   = 2'd1;
        end
        if (f1_reg.in_b) begin
            if (n == 2'd0) begin
                px0 = f1_reg.ctx.seg_end_x; py0 = f1_reg.ctx.seg_end_y;
            end else begin
                px1 = f1_reg.ctx.seg_end_x; py1 = f1_reg.ctx.seg_end_y;
            end
            n = n + 2'd1;
        end
        for (int j = 0; j < 4; j++) begin
            case (j)
                lrc_pkg::LANE_L: begin cx = f1_reg.ctx.rect_left;  cy = f1_reg.cval[j]; end
                lrc_pkg::LANE_R: begin cx = f1_reg.ctx.rect_right; cy = f1_reg.cval[j]; end
                lrc_pkg::LANE_T: begin cx = f1_reg.cval[j]; cy = f1_reg.ctx.rect_top;    end
                default:         begin cx = f1_reg.cval[j]; cy = f1_reg.ctx.rect_bottom; end
            endcase
            // left and top crossings drop a repeat of the one point held
            if (n < 2'd2 && f1_reg.acc[j] &&
                !((j == lrc_pkg::LANE_L || j == lrc_pkg::LANE_T) &&
                  n == 2'd1 && px0 == cx && py0 == cy)) begin
                if (n == 2'd0) begin
                    px0 = cx; py0 = cy;
                end else begin
                    px1 = cx; py1 = cy;
                end
                n = n + 2'd1;
            end
        end
        if (!f1_reg.degen && n == 2'd2 && !(px0 == px1 && py0 == py1)) begin
            o_next.clip_start_x = px0;
            o_next.clip_start_y = py0;
            o_next.clip_end_x   = px1;
            o_next.clip_end_y   = py1;
            o_next.has_overlap  = 1'b1;
        end else begin
            o_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end else begin
            if (rdy1) f1_v_reg <= in_valid;
            if (rdy2) o_v_reg  <= f1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) f1_reg <= f1_next;
        if (rdy2) o_reg  <= o_next;
    end

    assign out_valid = o_v_reg;
    assign out_data  = o_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/line_rect_clip_top.sv
// Top level of the line segment / rectangle clipper.
// Stages: two front stages, COORD_W divider stages, two back stages.
// Throughput: one item per cycle; every stage has its own valid bit and
//   advances whenever it is empty or the stage after it advances.
// Reset: synchronous, active low; clears all stage valid bits, payload is not reset.
`default_nettype none
module line_rect_clip_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire lrc_pkg::in_t s_item,
    output logic              m_valid,
    input  wire logic         m_ready,
    output lrc_pkg::out_t     m_item
);

    // front -> divider -> back, each with a valid/ready hop
    logic          f_valid, f_ready;
    lrc_pkg::div_t f_data;
    logic          d_valid, d_ready;
    lrc_pkg::div_t d_data;

    // differences, magnitudes and crossing signs, then products
    lrc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_data   (s_item),
        .in_ready  (s_ready),
        .out_valid (f_valid),
        .out_data  (f_data),
        .out_ready (f_ready)
    );

    // quotient of product by |dx| or |dy|, truncated toward zero via magnitudes
    lrc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_data   (f_data),
        .in_ready  (f_ready),
        .out_valid (d_valid),
        .out_data  (d_data),
        .out_ready (d_ready)
    );

    // crossing tests, point collection and the output register
    lrc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_valid),
        .in_data   (d_data),
        .in_ready  (d_ready),
        .out_valid (m_valid),
        .out_data  (m_item),
        .out_ready (m_ready)
    );

    // no overlap means an all-zero item
    a_zero_when_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.has_overlap |->
            m_item.clip_start_x == '0 && m_item.clip_start_y == '0 &&
            m_item.clip_end_x == '0 && m_item.clip_end_y == '0)
        else $error("clear overlap flag with nonzero points");

    // an overlapping item has two distinct points
    a_distinct_points: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.has_overlap |->
            !(m_item.clip_start_x == m_item.clip_end_x &&
              m_item.clip_start_y == m_item.clip_end_y))
        else $error("overlap reported for a single point");

    // the pipeline is empty straight after reset
    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule
`default_nettype wire

FILE: dv/line_rect_clip_top_tb.sv
// Self-checking testbench for the line segment / rectangle clipper.
`default_nettype none
module line_rect_clip_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    lrc_pkg::in_t  s_item = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    lrc_pkg::out_t m_item;

    line_rect_clip_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    lrc_pkg::in_t  pending_items[$];
    lrc_pkg::out_t expected_clips[$];
    int   error_count = 0;
    bit   stimulus_done = 1'b0;
    // sender pause: hold off until every expected clip has arrived
    bit   drain_request = 1'b0;
    // receiver hold-off length in cycles, taken up by the monitor
    int   long_stall_req = 0;
    // handshake levels seen at the last rising edge
    bit   s_ready_seen = 1'b0;
    bit   m_valid_seen = 1'b0;

    // base + trunc(t*m/d), exact in 64-bit arithmetic
    function automatic longint crossing_value(longint base, longint t, longint m, longint d);
        longint p;
        longint q;
        p = t * m;
        q = p / d;                  // SV division truncates toward zero
        return base + q;
    endfunction

    // Clipped segment for one item
    function automatic lrc_pkg::out_t clip_segment(lrc_pkg::in_t it);
        lrc_pkg::out_t res;
        longint l, t, r, b, ax, ay, bx, by, dx, dy, lo, hi, e, c;
        longint px[2];
        longint py[2];
        int     n;
        res = '0;
        l  = it.rect_left;   t  = it.rect_top;
        r  = it.rect_right;  b  = it.rect_bottom;
        ax = it.seg_start_x; ay = it.seg_start_y;
        bx = it.seg_end_x;   by = it.seg_end_y;
        dx = bx - ax; dy = by - ay;
        n = 0;
        px[0] = 0; px[1] = 0; py[0] = 0; py[1] = 0;
        if ((dx == 0 && dy == 0) || l == r || t == b)
            return res;
        // half-open endpoint test
        if (l <= ax && r > ax && t <= ay && b > ay) begin
            px[n] = ax; py[n] = ay; n++;
        end
        if (l <= bx && r > bx && t <= by && b > by) begin
            px[n] = bx; py[n] = by; n++;
        end
        // left then right crossing, closed bounds
        if (n < 2 && dx != 0) begin
            lo = (ax < bx) ? ax : bx;
            hi = (ax < bx) ? bx : ax;
            for (int k = 0; k < 2 && n < 2; k++) begin
                e = (k == 0) ? l : r;
                if (lo <= e && hi >= e) begin
                    c = crossing_value(ay, e - ax, dy, dx);
                    if (t <= c && c <= b &&
                        !(k == 0 && n == 1 && px[0] == e && py[0] == c)) begin
                        px[n] = e; py[n] = c; n++;
                    end
                end
            end
        end
        // top then bottom crossing
        if (n < 2 && dy != 0) begin
            lo = (ay < by) ? ay : by;
            hi = (ay < by) ? by : ay;
            for (int k = 0; k < 2 && n < 2; k++) begin
                e = (k == 0) ? t : b;
                if (lo <= e && hi >= e) begin
                    c = crossing_value(ax, e - ay, dx, dy);
                    if (l <= c && c <= r &&
                        !(k == 0 && n == 1 && px[0] == c && py[0] == e)) begin
                        px[n] = c; py[n] = e; n++;
                    end
                end
            end
        end
        if (n != 2 || (px[0] == px[1] && py[0] == py[1]))
            return res;
        res.clip_start_x = lrc_pkg::coord_t'(px[0]);
        res.clip_start_y = lrc_pkg::coord_t'(py[0]);
        res.clip_end_x   = lrc_pkg::coord_t'(px[1]);
        res.clip_end_y   = lrc_pkg::coord_t'(py[1]);
        res.has_overlap  = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Driver: changes inputs on the falling edge only
    int send_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready_seen) begin
                // item accepted on the last rising edge
                expected_clips.push_back(clip_segment(s_item));
                void'(pending_items.pop_front());
                send_gap = $urandom_range(0, 4);
            end
            if (!(s_valid && !s_ready_seen)) begin
                if (pending_items.size() > 0 && !drain_request && send_gap == 0) begin
                    s_item  <= pending_items[0];
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap--;
                end
            end
        end
    end

    // Acceptance seen at the rising edge, for the driver's next falling edge
    always @(posedge aclk)
        s_ready_seen <= s_ready;

    // Monitor: samples at the rising edge, drives m_ready at the falling edge
    int recv_gap = 0;
    always @(posedge aclk) begin
        lrc_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_clips.size() == 0) begin
                report_mismatch("unexpected clip", 1, 0);
            end else begin
                want = expected_clips.pop_front();
                if (m_item.clip_start_x !== want.clip_start_x)
                    report_mismatch("clip_start_x", m_item.clip_start_x, want.clip_start_x);
                if (m_item.clip_start_y !== want.clip_start_y)
                    report_mismatch("clip_start_y", m_item.clip_start_y, want.clip_start_y);
                if (m_item.clip_end_x !== want.clip_end_x)
                    report_mismatch("clip_end_x", m_item.clip_end_x, want.clip_end_x);
                if (m_item.clip_end_y !== want.clip_end_y)
                    report_mismatch("clip_end_y", m_item.clip_end_y, want.clip_end_y);
                if (m_item.has_overlap !== want.has_overlap)
                    report_mismatch("has_overlap", m_item.has_overlap, want.has_overlap);
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (long_stall_req > 0) begin
            m_ready <= 1'b0;
            long_stall_req--;
        end else if (m_ready && m_valid_seen) begin
            // one clip taken: draw the wait before the next
            recv_gap = $urandom_range(0, 4);
            m_ready <= (recv_gap == 0);
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= (recv_gap == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk)
        m_valid_seen <= m_valid;

    function automatic lrc_pkg::in_t make_item(int l, int t, int r, int b,
                                               int ax, int ay, int bx, int by);
        lrc_pkg::in_t it;
        it.rect_left   = lrc_pkg::coord_t'(l);
        it.rect_top    = lrc_pkg::coord_t'(t);
        it.rect_right  = lrc_pkg::coord_t'(r);
        it.rect_bottom = lrc_pkg::coord_t'(b);
        it.seg_start_x = lrc_pkg::coord_t'(ax);
        it.seg_start_y = lrc_pkg::coord_t'(ay);
        it.seg_end_x   = lrc_pkg::coord_t'(bx);
        it.seg_end_y   = lrc_pkg::coord_t'(by);
        return it;
    endfunction

    function automatic lrc_pkg::coord_t rand_coord(int mode);
        case (mode)
            0: return lrc_pkg::coord_t'($urandom);
            1: return lrc_pkg::coord_t'($urandom_range(0, 64) - 32);
            2: return lrc_pkg::coord_t'($urandom_range(0, 4) ? 16'sh7fff - $urandom_range(0, 3)
                                                           : 16'sh8000 + $urandom_range(0, 3));
            default: return lrc_pkg::coord_t'($urandom_range(0, 400) - 200);
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_valid || expected_clips.size() > 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    initial begin
        lrc_pkg::in_t it;
        int  mode;
        int  cx, cy;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: inside, crossing each edge, repeated corner points,
        // degenerate segment and rectangle, inverted rectangle, extremes
        pending_items.push_back(make_item(0, 0, 10, 10, 2, 2, 8, 8));
        pending_items.push_back(make_item(0, 0, 10, 10, -5, 5, 15, 5));
        pending_items.push_back(make_item(0, 0, 10, 10, 5, -5, 5, 15));
        pending_items.push_back(make_item(0, 0, 10, 10, -5, -5, 15, 15));
        pending_items.push_back(make_item(0, 0, 10, 10, 10, 10, -3, -3));
        pending_items.push_back(make_item(0, 0, 10, 10, 0, 0, -3, -3));
        pending_items.push_back(make_item(0, 0, 10, 10, 3, 3, 3, 3));
        pending_items.push_back(make_item(0, 0, 0, 10, -5, 5, 15, 5));
        pending_items.push_back(make_item(0, 0, 10, 0, -5, 5, 15, 5));
        pending_items.push_back(make_item(10, 10, 0, 0, -5, 5, 15, 5));
        pending_items.push_back(make_item(0, 0, 10, 10, 20, 20, 30, 31));
        pending_items.push_back(make_item(0, 0, 10, 10, -1, 11, 11, -1));
        pending_items.push_back(make_item(0, 0, 10, 10, 0, 5, 0, 20));
        pending_items.push_back(make_item(0, 0, 10, 10, -7, 3, 13, 6));
        pending_items.push_back(make_item(-32768, -32768, 32767, 32767,
                                          -32768, -32768, 32767, 32767));
        pending_items.push_back(make_item(-32768, -32768, 32767, 32767,
                                          32767, -32768, -32768, 32767));
        pending_items.push_back(make_item(-100, -100, 100, 100,
                                          -32768, 32767, 32767, -32768));
        pending_items.push_back(make_item(32767, 32767, -32768, -32768,
                                          0, 0, 1, 1));
        pending_items.push_back(make_item(0, 0, 10, 10, 10, -5, 10, 15));
        pending_items.push_back(make_item(0, 0, 10, 10, -5, 10, 15, 10));
        wait_idle();

        // Random, with one long receiver stall while items keep flowing
        for (int i = 0; i < 2000; i++) begin
            if (i == 300)
                long_stall_req = 200;
            if (i == 1000) begin
                // sender pause until all clips are back
                while (s_valid || pending_items.size() > 0)
                    @(posedge aclk);
                drain_request = 1'b1;
                while (expected_clips.size() > 0)
                    @(posedge aclk);
                drain_request = 1'b0;
            end
            mode = $urandom_range(0, 9);
            if (mode < 6) begin
                // well-formed rectangle with a segment near it
                it.rect_left   = rand_coord(mode < 3 ? 3 : 1);
                it.rect_top    = rand_coord(mode < 3 ? 3 : 1);
                it.rect_right  = it.rect_left + lrc_pkg::coord_t'($urandom_range(1, 150));
                it.rect_bottom = it.rect_top + lrc_pkg::coord_t'($urandom_range(1, 150));
                cx = it.rect_left; cy = it.rect_top;
                it.seg_start_x = lrc_pkg::coord_t'(cx + $urandom_range(0, 300) - 75);
                it.seg_start_y = lrc_pkg::coord_t'(cy + $urandom_range(0, 300) - 75);
                it.seg_end_x   = lrc_pkg::coord_t'(cx + $urandom_range(0, 300) - 75);
                it.seg_end_y   = lrc_pkg::coord_t'(cy + $urandom_range(0, 300) - 75);
                if (mode == 5) it.seg_end_x = it.seg_start_x;
                if (mode == 4) it.seg_end_y = it.rect_top;
            end else begin
                it.rect_left   = rand_coord(mode - 6);
                it.rect_top    = rand_coord(mode - 6);
                it.rect_right  = rand_coord(mode - 6);
                it.rect_bottom = rand_coord(mode - 6);
                it.seg_start_x = rand_coord(mode - 6);
                it.seg_start_y = rand_coord(mode - 6);
                it.seg_end_x   = rand_coord(mode - 6);
                it.seg_end_y   = rand_coord(mode - 6);
            end
            pending_items.push_back(it);
            // keep the queue shallow so gaps land everywhere
            while (pending_items.size() > 8)
                @(posedge aclk);
        end
        wait_idle();
        stimulus_done = 1'b1;
    end

    initial begin
        wait (stimulus_done);
        @(posedge aclk);
        if (error_count == 0 && expected_clips.size() == 0) begin
            $display("line_rect_clip_top_tb: clean");
        end else begin
            $display("line_rect_clip_top_tb: errors");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("line_rect_clip_top_tb: errors");
        $finish;
    end
endmodule
`default_nettype wire
